@@ hdl/ftpr_pkg.sv @@
// Shared types, codes and widths of the fault table priority reporter.
`default_nettype none

package ftpr_pkg;

   localparam int ENTRIES_DEFAULT    = 16;
   localparam int CODE_WIDTH_DEFAULT = 16;

   // Port field widths.
   localparam int MODE_W     = 3;
   localparam int INDEX_W    = 4;
   localparam int FCODE_W    = 16;
   localparam int LEVEL_W    = 2;
   localparam int STATUS_W   = 2;
   localparam int EIU_W      = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [EIU_W-1:0] EIU_RESET = 5'd16;

   // The running best level needs one code above the highest level so that
   // the first active entry always wins when the order is reversed.
   localparam int LEVEL_TOP = 3;
   localparam int BEST_W    = 3;
   localparam logic [BEST_W-1:0] BEST_INIT_REVERSED = 3'(LEVEL_TOP + 1);

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD      = 3'd0,
      MODE_SET       = 3'd1,
      MODE_CLEAR     = 3'd2,
      MODE_SET_ALL   = 3'd3,
      MODE_CLEAR_ALL = 3'd4,
      MODE_TICK      = 3'd5
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_INVALID   = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      REG_ENTRIES_IN_USE = 1'b0,
      REG_LEVEL_ORDER    = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic wr_en;
      logic act_we;
      logic act_val;
   } tbl_cmd_type;

   function automatic int index_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   function automatic int count_width(input int depth);
      return $clog2(depth + 1);
   endfunction

endpackage

`default_nettype wire

@@ hdl/ftpr_req_if.sv @@
// Request channel of the fault table priority reporter.
`default_nettype none

interface ftpr_req_if;
   logic                          valid;
   logic                          ready;
   logic [ftpr_pkg::MODE_W-1:0]   mode;
   logic [ftpr_pkg::INDEX_W-1:0]  entry_index;
   logic [ftpr_pkg::FCODE_W-1:0]  fault_code;
   logic [ftpr_pkg::LEVEL_W-1:0]  fault_level;

   modport source (output valid, mode, entry_index, fault_code, fault_level, input ready);
   modport sink (input valid, mode, entry_index, fault_code, fault_level, output ready);
   modport monitor (input valid, ready, mode, entry_index, fault_code, fault_level);
endinterface

`default_nettype wire

@@ hdl/ftpr_rsp_if.sv @@
// Response channel of the fault table priority reporter.
`default_nettype none

interface ftpr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ftpr_pkg::STATUS_W-1:0] status;
   logic [ftpr_pkg::LEVEL_W-1:0]  report_level;
   logic [ftpr_pkg::FCODE_W-1:0]  report_code;

   modport source (output valid, status, report_level, report_code, input ready);
   modport sink (input valid, status, report_level, report_code, output ready);
   modport monitor (input valid, ready, status, report_level, report_code);
endinterface

`default_nettype wire

@@ hdl/ftpr_csr.sv @@
// APB-style configuration registers of the fault table priority reporter.
`default_nettype none

module ftpr_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ftpr_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [ftpr_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [ftpr_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output logic [ftpr_pkg::EIU_W-1:0]        entries_in_use,
   output logic                              level_order_reversed
);

   logic [ftpr_pkg::EIU_W-1:0] eiu_ff, eiu_in;
   logic                       rev_ff, rev_in;
   logic                       wr_strobe;
   ftpr_pkg::reg_index_type    reg_sel;

   assign pready    = 1'b1;
   assign wr_strobe = psel && penable && pwrite;
   assign reg_sel   = ftpr_pkg::reg_index_type'(paddr[2]);

   always_comb begin
      eiu_in = eiu_ff;
      rev_in = rev_ff;
      prdata = '0;
      case (reg_sel)
         ftpr_pkg::REG_ENTRIES_IN_USE: begin
            prdata = ftpr_pkg::CSR_DATA_W'(eiu_ff);
            if (wr_strobe) begin
               eiu_in = pwdata[ftpr_pkg::EIU_W-1:0];
            end
         end
         ftpr_pkg::REG_LEVEL_ORDER: begin
            prdata = ftpr_pkg::CSR_DATA_W'(rev_ff);
            if (wr_strobe) begin
               rev_in = pwdata[0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eiu_ff <= ftpr_pkg::EIU_RESET;
         rev_ff <= 1'b0;
      end else begin
         eiu_ff <= eiu_in;
         rev_ff <= rev_in;
      end
   end

   assign entries_in_use       = eiu_ff;
   assign level_order_reversed = rev_ff;

endmodule

`default_nettype wire

@@ hdl/ftpr_table.sv @@
// Fault entry store: code and level memory with one registered read port,
// written bits and active flags.
`default_nettype none

module ftpr_table #(
   parameter  int ENTRIES    = ftpr_pkg::ENTRIES_DEFAULT,
   parameter  int CODE_WIDTH = ftpr_pkg::CODE_WIDTH_DEFAULT,
   localparam int IDX_W      = ftpr_pkg::index_width(ENTRIES)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  ftpr_pkg::tbl_cmd_type            cmd,
   input  logic [IDX_W-1:0]                 cmd_idx,
   input  logic [CODE_WIDTH-1:0]            wr_code,
   input  logic [ftpr_pkg::LEVEL_W-1:0]     wr_level,
   input  logic [IDX_W-1:0]                 rd_addr,
   output logic [CODE_WIDTH-1:0]            rd_code,
   output logic [ftpr_pkg::LEVEL_W-1:0]     rd_level,
   output logic [ENTRIES-1:0]               active
);

   logic [CODE_WIDTH-1:0]        code_mem  [ENTRIES];
   logic [ftpr_pkg::LEVEL_W-1:0] level_mem [ENTRIES];

   logic [ENTRIES-1:0]           written_ff, written_in;
   logic [ENTRIES-1:0]           active_ff, active_in;
   logic [CODE_WIDTH-1:0]        rd_code_raw_ff;
   logic [ftpr_pkg::LEVEL_W-1:0] rd_level_raw_ff;
   logic                         rd_written_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         code_mem[cmd_idx]  <= wr_code;
         level_mem[cmd_idx] <= wr_level;
      end
      rd_code_raw_ff  <= code_mem[rd_addr];
      rd_level_raw_ff <= level_mem[rd_addr];
   end

   // An entry never loaded since reset reads as code zero and level zero.
   always_comb begin
      written_in = written_ff;
      active_in  = active_ff;
      if (cmd.wr_en) begin
         written_in[cmd_idx] = 1'b1;
         active_in[cmd_idx]  = 1'b0;
      end
      if (cmd.act_we) begin
         active_in[cmd_idx] = cmd.act_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         active_ff     <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         written_ff    <= written_in;
         active_ff     <= active_in;
         rd_written_ff <= written_ff[rd_addr];
      end
   end

   assign rd_code  = rd_written_ff ? rd_code_raw_ff : '0;
   assign rd_level = rd_written_ff ? rd_level_raw_ff : '0;
   assign active   = active_ff;

endmodule

`default_nettype wire

@@ hdl/ftpr_ctrl.sv @@
// Sequencer walking the fault table one entry per cycle for matching, bulk
// updates, level scan and rotation; match and scan share a compare unit.
`default_nettype none

module ftpr_ctrl #(
   parameter  int ENTRIES    = ftpr_pkg::ENTRIES_DEFAULT,
   parameter  int CODE_WIDTH = ftpr_pkg::CODE_WIDTH_DEFAULT,
   localparam int IDX_W      = ftpr_pkg::index_width(ENTRIES)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [ftpr_pkg::MODE_W-1:0]      req_mode,
   input  logic [ftpr_pkg::INDEX_W-1:0]     req_entry_index,
   input  logic [ftpr_pkg::FCODE_W-1:0]     req_fault_code,
   input  logic [ftpr_pkg::LEVEL_W-1:0]     req_fault_level,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [ftpr_pkg::STATUS_W-1:0]    rsp_status,
   output logic [ftpr_pkg::LEVEL_W-1:0]     rsp_report_level,
   output logic [ftpr_pkg::FCODE_W-1:0]     rsp_report_code,
   input  logic [ftpr_pkg::EIU_W-1:0]       cfg_entries_in_use,
   input  logic                             cfg_level_order_reversed,
   output ftpr_pkg::tbl_cmd_type            tbl_cmd,
   output logic [IDX_W-1:0]                 tbl_idx,
   output logic [CODE_WIDTH-1:0]            tbl_wr_code,
   output logic [ftpr_pkg::LEVEL_W-1:0]     tbl_wr_level,
   output logic [IDX_W-1:0]                 tbl_rd_addr,
   input  logic [CODE_WIDTH-1:0]            tbl_rd_code,
   input  logic [ftpr_pkg::LEVEL_W-1:0]     tbl_rd_level,
   input  logic [ENTRIES-1:0]               tbl_active
);

   localparam int CNT_W = ftpr_pkg::count_width(ENTRIES);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_MATCH,
      S_BULK,
      S_LEVEL,
      S_ROTATE,
      S_FETCH,
      S_RESPOND
   } state_type;

   state_type                    state_ff, state_in;
   ftpr_pkg::mode_type           mode_ff, mode_in;
   logic [CODE_WIDTH-1:0]        code_ff, code_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [ftpr_pkg::LEVEL_W-1:0] level_ff, level_in;
   logic [CNT_W-1:0]             n_ff, n_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0]             pipe_idx_ff, pipe_idx_in;
   logic [ftpr_pkg::BEST_W-1:0]  best_ff, best_in;
   logic                         found_ff, found_in;
   logic [IDX_W-1:0]             ptr_ff, ptr_in;
   logic [IDX_W-1:0]             k_ff, k_in;
   ftpr_pkg::status_type         res_status_ff, res_status_in;
   logic [ftpr_pkg::LEVEL_W-1:0] res_level_ff, res_level_in;
   logic [ftpr_pkg::FCODE_W-1:0] res_code_ff, res_code_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   ftpr_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [ftpr_pkg::LEVEL_W-1:0] rsp_level_ff, rsp_level_in;
   logic [ftpr_pkg::FCODE_W-1:0] rsp_code_ff, rsp_code_in;

   logic                         issue;
   logic [CNT_W-1:0]             n_span;
   logic [31:0]                  idx_ext;
   logic [31:0]                  req_code_ext;
   logic [31:0]                  rd_code_ext;
   logic [ftpr_pkg::BEST_W-1:0]  rd_level_ext;
   logic                         more_serious;
   logic                         code_hit;
   logic [CNT_W-1:0]             k_plus;
   logic [IDX_W-1:0]             k_next;
   logic [IDX_W-1:0]             scan_start;

   assign req_ready = (state_ff == S_IDLE);
   assign issue     = (cnt_ff < n_ff);

   // Entries in use saturate at the table depth.
   assign n_span = (32'(cfg_entries_in_use) > 32'(ENTRIES)) ? CNT_W'(ENTRIES)
                                                             : CNT_W'(cfg_entries_in_use);

   assign idx_ext      = 32'(req_entry_index);
   assign req_code_ext = 32'(req_fault_code);
   assign rd_code_ext  = 32'(tbl_rd_code);
   assign rd_level_ext = ftpr_pkg::BEST_W'(tbl_rd_level);

   // Shared compare unit: the code match and the level order test.
   assign code_hit     = (tbl_rd_code == code_ff);
   assign more_serious = cfg_level_order_reversed ? (rd_level_ext < best_ff)
                                                  : (rd_level_ext > best_ff);

   assign k_plus     = CNT_W'(k_ff) + CNT_W'(1);
   assign k_next     = (k_plus >= n_ff) ? '0 : k_plus[IDX_W-1:0];
   assign scan_start = (CNT_W'(ptr_ff) < n_ff) ? ptr_ff : '0;

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      code_in       = code_ff;
      idx_in        = idx_ff;
      level_in      = level_ff;
      n_in          = n_ff;
      cnt_in        = cnt_ff;
      pipe_vld_in   = 1'b0;
      pipe_idx_in   = pipe_idx_ff;
      best_in       = best_ff;
      found_in      = found_ff;
      ptr_in        = ptr_ff;
      k_in          = k_ff;
      res_status_in = res_status_ff;
      res_level_in  = res_level_ff;
      res_code_in   = res_code_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_code_in   = rsp_code_ff;

      tbl_cmd       = '0;
      tbl_idx       = idx_ff;
      tbl_wr_code   = code_ff;
      tbl_wr_level  = level_ff;
      tbl_rd_addr   = cnt_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in       = ftpr_pkg::mode_type'(req_mode);
               code_in       = req_code_ext[CODE_WIDTH-1:0];
               idx_in        = idx_ext[IDX_W-1:0];
               level_in      = req_fault_level;
               n_in          = n_span;
               cnt_in        = '0;
               found_in      = 1'b0;
               best_in       = cfg_level_order_reversed ? ftpr_pkg::BEST_INIT_REVERSED : '0;
               res_status_in = ftpr_pkg::ST_OK;
               res_level_in  = '0;
               res_code_in   = '0;
               case (ftpr_pkg::mode_type'(req_mode))
                  ftpr_pkg::MODE_LOAD: begin
                     if (idx_ext >= 32'(ENTRIES)) begin
                        res_status_in = ftpr_pkg::ST_INVALID;
                        state_in      = S_RESPOND;
                     end else begin
                        state_in = S_LOAD;
                     end
                  end
                  ftpr_pkg::MODE_SET, ftpr_pkg::MODE_CLEAR: begin
                     state_in = S_MATCH;
                  end
                  ftpr_pkg::MODE_SET_ALL, ftpr_pkg::MODE_CLEAR_ALL: begin
                     state_in = S_BULK;
                  end
                  ftpr_pkg::MODE_TICK: begin
                     state_in = S_LEVEL;
                  end
                  default: begin
                     res_status_in = ftpr_pkg::ST_INVALID;
                     state_in      = S_RESPOND;
                  end
               endcase
            end
         end

         S_LOAD: begin
            tbl_cmd.wr_en = 1'b1;
            state_in      = S_RESPOND;
         end

         // Each read is issued the cycle before its compare, so the entry
         // under test is tagged with its index.
         S_MATCH: begin
            pipe_vld_in = issue;
            pipe_idx_in = cnt_ff[IDX_W-1:0];
            if (issue) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (pipe_vld_ff && code_hit) begin
               tbl_cmd.act_we  = 1'b1;
               tbl_cmd.act_val = (mode_ff == ftpr_pkg::MODE_SET);
               tbl_idx         = pipe_idx_ff;
               pipe_vld_in     = 1'b0;
               state_in        = S_RESPOND;
            end else if (!issue && !pipe_vld_ff) begin
               res_status_in = ftpr_pkg::ST_NOT_FOUND;
               state_in      = S_RESPOND;
            end
         end

         S_BULK: begin
            if (issue) begin
               tbl_cmd.act_we  = 1'b1;
               tbl_cmd.act_val = (mode_ff == ftpr_pkg::MODE_SET_ALL);
               tbl_idx         = cnt_ff[IDX_W-1:0];
               cnt_in          = cnt_ff + CNT_W'(1);
            end else begin
               state_in = S_RESPOND;
            end
         end

         S_LEVEL: begin
            pipe_vld_in = issue;
            pipe_idx_in = cnt_ff[IDX_W-1:0];
            if (issue) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (pipe_vld_ff) begin
               if (tbl_active[pipe_idx_ff]) begin
                  found_in = 1'b1;
                  if (more_serious) begin
                     best_in = rd_level_ext;
                  end
               end
            end else if (!issue) begin
               // Nothing to report: no active entry, or in normal order
               // every active entry sits at level none.
               if (!found_ff || (!cfg_level_order_reversed && best_ff == '0)) begin
                  state_in = S_RESPOND;
               end else begin
                  k_in     = scan_start;
                  state_in = S_ROTATE;
               end
            end
         end

         S_ROTATE: begin
            tbl_rd_addr = k_ff;
            if (tbl_active[k_ff]) begin
               ptr_in   = k_next;
               state_in = S_FETCH;
            end else begin
               k_in = k_next;
            end
         end

         S_FETCH: begin
            res_level_in = best_ff[ftpr_pkg::LEVEL_W-1:0];
            res_code_in  = rd_code_ext[ftpr_pkg::FCODE_W-1:0];
            state_in     = S_RESPOND;
         end

         S_RESPOND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_level_in  = res_level_ff;
               rsp_code_in   = res_code_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pipe_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pipe_vld_ff  <= pipe_vld_in;
         found_ff     <= found_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      code_ff       <= code_in;
      idx_ff        <= idx_in;
      level_ff      <= level_in;
      n_ff          <= n_in;
      pipe_idx_ff   <= pipe_idx_in;
      best_ff       <= best_in;
      k_ff          <= k_in;
      res_status_ff <= res_status_in;
      res_level_ff  <= res_level_in;
      res_code_ff   <= res_code_in;
      rsp_status_ff <= rsp_status_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_code_ff   <= rsp_code_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_report_level = rsp_level_ff;
   assign rsp_report_code  = rsp_code_ff;

endmodule

`default_nettype wire

@@ hdl/fault_table_priority_reporter.sv @@
// Top level of the fault table priority reporter.
// The block holds ENTRIES fault entries (code, level, active flag) and takes
// one request beat at a time: load an entry, set or clear the first entry
// with a matching code, set or clear all entries in use, or tick, which
// reports the most serious active level and the next active code in
// round-robin order; undefined modes get an invalid status. Every request
// gives exactly one response beat. Matching, the level pass and the rotation
// go through a single registered read port on the entry memory, one entry per
// cycle; a tick makes a level pass over the table, then a rotation walk from
// the pointer. The request side is not ready while an item is in progress; a
// finished response waits in its own register, so the next request is taken
// while the previous response is still unclaimed. No clearing pass follows
// reset: per-entry written and active flags clear at once. Configuration is
// to be written through the APB-style port only while idle; the block itself
// does not enforce this.
`default_nettype none

module fault_table_priority_reporter #(
   parameter int ENTRIES    = ftpr_pkg::ENTRIES_DEFAULT,
   parameter int CODE_WIDTH = ftpr_pkg::CODE_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   ftpr_req_if.sink                         req,
   ftpr_rsp_if.source                       rsp,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [ftpr_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [ftpr_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [ftpr_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);

   localparam int IDX_W = ftpr_pkg::index_width(ENTRIES);

   logic [ftpr_pkg::EIU_W-1:0]   entries_in_use;
   logic                         level_order_reversed;
   ftpr_pkg::tbl_cmd_type        tbl_cmd;
   logic [IDX_W-1:0]             tbl_idx;
   logic [CODE_WIDTH-1:0]        tbl_wr_code;
   logic [ftpr_pkg::LEVEL_W-1:0] tbl_wr_level;
   logic [IDX_W-1:0]             tbl_rd_addr;
   logic [CODE_WIDTH-1:0]        tbl_rd_code;
   logic [ftpr_pkg::LEVEL_W-1:0] tbl_rd_level;
   logic [ENTRIES-1:0]           tbl_active;

   ftpr_csr u_csr (
      .clock                (clock),
      .reset                (reset),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready),
      .entries_in_use       (entries_in_use),
      .level_order_reversed (level_order_reversed)
   );

   ftpr_table #(
      .ENTRIES    (ENTRIES),
      .CODE_WIDTH (CODE_WIDTH)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .cmd      (tbl_cmd),
      .cmd_idx  (tbl_idx),
      .wr_code  (tbl_wr_code),
      .wr_level (tbl_wr_level),
      .rd_addr  (tbl_rd_addr),
      .rd_code  (tbl_rd_code),
      .rd_level (tbl_rd_level),
      .active   (tbl_active)
   );

   ftpr_ctrl #(
      .ENTRIES    (ENTRIES),
      .CODE_WIDTH (CODE_WIDTH)
   ) u_ctrl (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req.valid),
      .req_ready                (req.ready),
      .req_mode                 (req.mode),
      .req_entry_index          (req.entry_index),
      .req_fault_code           (req.fault_code),
      .req_fault_level          (req.fault_level),
      .rsp_valid                (rsp.valid),
      .rsp_ready                (rsp.ready),
      .rsp_status               (rsp.status),
      .rsp_report_level         (rsp.report_level),
      .rsp_report_code          (rsp.report_code),
      .cfg_entries_in_use       (entries_in_use),
      .cfg_level_order_reversed (level_order_reversed),
      .tbl_cmd                  (tbl_cmd),
      .tbl_idx                  (tbl_idx),
      .tbl_wr_code              (tbl_wr_code),
      .tbl_wr_level             (tbl_wr_level),
      .tbl_rd_addr              (tbl_rd_addr),
      .tbl_rd_code              (tbl_rd_code),
      .tbl_rd_level             (tbl_rd_level),
      .tbl_active               (tbl_active)
   );

endmodule

`default_nettype wire

@@ hdl/ftpr_checker.sv @@
// Port-level assertions of the fault table priority reporter and their bind.
`default_nettype none

module ftpr_checker (
   input logic        clock,
   input logic        reset,
   ftpr_req_if.sink   req,
   ftpr_rsp_if.source rsp,
   input logic        pready
);

   // One item at a time: the request side drops ready after a beat.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("request ready stayed high after an accepted beat");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.status == ftpr_pkg::ST_OK || rsp.status == ftpr_pkg::ST_INVALID
                     || rsp.status == ftpr_pkg::ST_NOT_FOUND))
      else $error("response carries an undefined status");

   // A failed request never reports a fault.
   a_error_no_report: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status != ftpr_pkg::ST_OK |->
         rsp.report_level == '0 && rsp.report_code == '0)
      else $error("error response carries a report");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status)
         && $stable(rsp.report_level) && $stable(rsp.report_code))
      else $error("stalled response beat changed");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("configuration port inserted a wait state");

endmodule

bind fault_table_priority_reporter ftpr_checker u_ftpr_checker (
   .clock  (clock),
   .reset  (reset),
   .req    (req),
   .rsp    (rsp),
   .pready (pready)
);

`default_nettype wire

@@ dv/tb_fault_table_priority_reporter.sv @@
// Self-checking testbench for the fault table priority reporter: directed and random traffic.
`timescale 1ns / 100ps

module tb_fault_table_priority_reporter;

   localparam int TABLE_DEPTH      = ftpr_pkg::ENTRIES_DEFAULT;
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int SETTLE_CYCLES    = 2 * TABLE_DEPTH + 8;

   // Mode encodings that the block has to reject.
   localparam logic [ftpr_pkg::MODE_W-1:0] MODE_UNDEFINED_LO = 3'd6;
   localparam logic [ftpr_pkg::MODE_W-1:0] MODE_UNDEFINED_HI = 3'd7;

   typedef struct packed {
      ftpr_pkg::status_type          status;
      logic [ftpr_pkg::LEVEL_W-1:0]  level;
      logic [ftpr_pkg::FCODE_W-1:0]  code;
   } fault_report_type;

   logic clock = 1'b0;
   logic reset;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [ftpr_pkg::CSR_ADDR_W-1:0] paddr;
   logic [ftpr_pkg::CSR_DATA_W-1:0] pwdata;
   logic [ftpr_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   ftpr_req_if req_bus ();
   ftpr_rsp_if rsp_bus ();

   fault_table_priority_reporter dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the fault table and its configuration.
   logic [ftpr_pkg::FCODE_W-1:0] tbl_code   [TABLE_DEPTH];
   logic [ftpr_pkg::LEVEL_W-1:0] tbl_level  [TABLE_DEPTH];
   bit                           tbl_active [TABLE_DEPTH];
   int                           rr_pointer;
   int                           span_cfg;
   bit                           order_reversed;

   fault_report_type expected_reports[$];
   int  error_count     = 0;
   int  quiet_cycles    = 0;
   int  gap_before_next = 0;
   bit  idling_on       = 1'b1;
   bit  hold_off_next   = 1'b0;

   task automatic report_error(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      error_count++;
   endtask

   function automatic void reset_table_model();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         tbl_code[i]   = '0;
         tbl_level[i]  = '0;
         tbl_active[i] = 1'b0;
      end
      rr_pointer     = 0;
      span_cfg       = int'(ftpr_pkg::EIU_RESET);
      order_reversed = 1'b0;
   endfunction

   // Applies one request to the shadow table and returns the report it must produce.
   function automatic fault_report_type apply_to_table(
         input logic [ftpr_pkg::MODE_W-1:0]  m,
         input logic [ftpr_pkg::INDEX_W-1:0] idx,
         input logic [ftpr_pkg::FCODE_W-1:0] code,
         input logic [ftpr_pkg::LEVEL_W-1:0] lvl);
      fault_report_type r;
      int  n;
      int  i;
      int  k;
      int  best;
      int  start;
      bit  found;
      bit  hit;
      r.status = ftpr_pkg::ST_OK;
      r.level  = '0;
      r.code   = '0;
      n        = (span_cfg > TABLE_DEPTH) ? TABLE_DEPTH : span_cfg;
      found    = 1'b0;
      hit      = 1'b0;
      case (m)
         ftpr_pkg::MODE_LOAD: begin
            if (idx >= TABLE_DEPTH) begin
               r.status = ftpr_pkg::ST_INVALID;
            end else begin
               tbl_code[idx]   = code;
               tbl_level[idx]  = lvl;
               tbl_active[idx] = 1'b0;
            end
         end
         ftpr_pkg::MODE_SET, ftpr_pkg::MODE_CLEAR: begin
            r.status = ftpr_pkg::ST_NOT_FOUND;
            for (i = 0; i < n && !hit; i++) begin
               if (tbl_code[i] == code) begin
                  tbl_active[i] = (m == ftpr_pkg::MODE_SET);
                  r.status      = ftpr_pkg::ST_OK;
                  hit           = 1'b1;
               end
            end
         end
         ftpr_pkg::MODE_SET_ALL, ftpr_pkg::MODE_CLEAR_ALL: begin
            for (i = 0; i < n; i++) tbl_active[i] = (m == ftpr_pkg::MODE_SET_ALL);
         end
         ftpr_pkg::MODE_TICK: begin
            best = order_reversed ? int'(ftpr_pkg::BEST_INIT_REVERSED) : 0;
            for (i = 0; i < n; i++) begin
               if (tbl_active[i]) begin
                  found = 1'b1;
                  if (order_reversed ? (tbl_level[i] < best) : (tbl_level[i] > best))
                     best = tbl_level[i];
               end
            end
            // In normal order a table whose active entries are all at level zero
            // reports nothing and the pointer stays where it is.
            if (found && (order_reversed || best != 0)) begin
               start = (rr_pointer < n) ? rr_pointer : 0;
               for (i = 0; i < n && !hit; i++) begin
                  k = start + i;
                  if (k >= n) k -= n;
                  if (tbl_active[k]) begin
                     rr_pointer = (k + 1 >= n) ? 0 : k + 1;
                     r.level    = best[ftpr_pkg::LEVEL_W-1:0];
                     r.code     = tbl_code[k];
                     hit        = 1'b1;
                  end
               end
            end
         end
         default: r.status = ftpr_pkg::ST_INVALID;
      endcase
      return r;
   endfunction

   // Offers one request beat and records the expected report once it is taken.
   task automatic send_fault_item(input logic [ftpr_pkg::MODE_W-1:0]  m,
                                  input logic [ftpr_pkg::INDEX_W-1:0] idx,
                                  input logic [ftpr_pkg::FCODE_W-1:0] code,
                                  input logic [ftpr_pkg::LEVEL_W-1:0] lvl);
      fault_report_type want;
      if (gap_before_next > 0) repeat (gap_before_next) @(posedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.mode        <= m;
      req_bus.entry_index <= idx;
      req_bus.fault_code  <= code;
      req_bus.fault_level <= lvl;
      do @(posedge clock); while (!req_bus.ready);
      want = apply_to_table(m, idx, code, lvl);
      expected_reports.push_back(want);
      // The gap before the next beat is drawn now so that valid stays high
      // without a glitch when there is none.
      gap_before_next = idling_on ? $urandom_range(0, 7) : 0;
      if (gap_before_next > 0) req_bus.valid <= 1'b0;
   endtask

   task automatic wait_for_reports();
      if (gap_before_next == 0) req_bus.valid <= 1'b0;
      gap_before_next = 0;
      do @(posedge clock); while (expected_reports.size() != 0);
   endtask

   task automatic csr_write(input ftpr_pkg::reg_index_type which,
                            input logic [ftpr_pkg::CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ftpr_pkg::CSR_ADDR_W'(int'(which) * 4);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (which)
         ftpr_pkg::REG_ENTRIES_IN_USE: span_cfg = int'(value[ftpr_pkg::EIU_W-1:0]);
         ftpr_pkg::REG_LEVEL_ORDER:    order_reversed = value[0];
         default: ;
      endcase
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly codes already in the table, so that set and clear find something.
   function automatic logic [ftpr_pkg::FCODE_W-1:0] pick_known_code();
      if ($urandom_range(0, 9) < 7) return tbl_code[$urandom_range(0, TABLE_DEPTH - 1)];
      if ($urandom_range(0, 1) == 0) return ftpr_pkg::FCODE_W'($urandom_range(0, 7));
      return ftpr_pkg::FCODE_W'($urandom);
   endfunction

   task automatic send_random_item();
      int                           sel;
      logic [ftpr_pkg::MODE_W-1:0]  m;
      logic [ftpr_pkg::FCODE_W-1:0] code;
      sel  = $urandom_range(0, 99);
      code = ftpr_pkg::FCODE_W'($urandom);
      if (sel < 24) begin
         m = ftpr_pkg::MODE_LOAD;
         if ($urandom_range(0, 1) == 0) code = ftpr_pkg::FCODE_W'($urandom_range(0, 7));
      end else if (sel < 48) begin
         m    = ftpr_pkg::MODE_SET;
         code = pick_known_code();
      end else if (sel < 62) begin
         m    = ftpr_pkg::MODE_CLEAR;
         code = pick_known_code();
      end else if (sel < 67) m = ftpr_pkg::MODE_SET_ALL;
      else if (sel < 72) m = ftpr_pkg::MODE_CLEAR_ALL;
      else if (sel < 96) m = ftpr_pkg::MODE_TICK;
      else if (sel < 98) m = MODE_UNDEFINED_LO;
      else m = MODE_UNDEFINED_HI;
      send_fault_item(m, ftpr_pkg::INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)), code,
                      ftpr_pkg::LEVEL_W'($urandom_range(0, 3)));
   endtask

   task automatic run_random_phase(input int span_value, input bit reversed, input int count,
                                   input bit with_idling);
      wait_for_reports();
      csr_write(ftpr_pkg::REG_ENTRIES_IN_USE, span_value);
      csr_write(ftpr_pkg::REG_LEVEL_ORDER, ftpr_pkg::CSR_DATA_W'(reversed));
      idling_on = with_idling;
      repeat (count) send_random_item();
   endtask

   task automatic test_directed_table_ops();
      send_fault_item(ftpr_pkg::MODE_TICK, 4'd0, 16'h0000, 2'd0);
      send_fault_item(ftpr_pkg::MODE_LOAD, 4'd0, 16'hFFFF, 2'd3);
      send_fault_item(ftpr_pkg::MODE_LOAD, 4'd15, 16'h0001, 2'd1);
      send_fault_item(ftpr_pkg::MODE_LOAD, 4'd5, 16'h8000, 2'd2);
      send_fault_item(ftpr_pkg::MODE_LOAD, 4'd7, 16'h1234, 2'd0);
      send_fault_item(ftpr_pkg::MODE_SET, 4'd0, 16'hFFFF, 2'd0);
      send_fault_item(ftpr_pkg::MODE_SET, 4'd3, 16'hABCD, 2'd3);
      send_fault_item(ftpr_pkg::MODE_CLEAR, 4'd9, 16'hABCD, 2'd1);
      send_fault_item(ftpr_pkg::MODE_TICK, 4'd0, 16'h0000, 2'd0);
      send_fault_item(ftpr_pkg::MODE_SET, 4'd0, 16'h0001, 2'd0);
      send_fault_item(ftpr_pkg::MODE_SET, 4'd0, 16'h8000, 2'd0);
      // Three ticks walk the pointer around and wrap it past the last entry.
      send_fault_item(ftpr_pkg::MODE_TICK, 4'd0, 16'h0000, 2'd0);
      send_fault_item(ftpr_pkg::MODE_TICK, 4'd0, 16'h0000, 2'd0);
      send_fault_item(ftpr_pkg::MODE_TICK, 4'd0, 16'h0000, 2'd0);
      send_fault_item(ftpr_pkg::MODE_LOAD, 4'd0, 16'hFFFF, 2'd3);
      send_fault_item(ftpr_pkg::MODE_TICK, 4'd15, 16'hFFFF, 2'd3);
      send_fault_item(ftpr_pkg::MODE_CLEAR_ALL, 4'd0, 16'h0000, 2'd0);
      send_fault_item(ftpr_pkg::MODE_TICK, 4'd0, 16'h0000, 2'd0);
      // Only a level-zero entry is active: nothing is reported.
      send_fault_item(ftpr_pkg::MODE_SET, 4'd0, 16'h1234, 2'd0);
      send_fault_item(ftpr_pkg::MODE_TICK, 4'd0, 16'h0000, 2'd0);
      send_fault_item(ftpr_pkg::MODE_SET_ALL, 4'd0, 16'h0000, 2'd0);
      send_fault_item(ftpr_pkg::MODE_TICK, 4'd0, 16'h0000, 2'd0);
      send_fault_item(MODE_UNDEFINED_LO, 4'd15, 16'hFFFF, 2'd3);
      send_fault_item(MODE_UNDEFINED_HI, 4'd0, 16'h0000, 2'd0);
      send_fault_item(ftpr_pkg::MODE_CLEAR, 4'd0, 16'h0000, 2'd0);
   endtask

   task automatic test_span_and_order_edges();
      // No entry in use: nothing matches and a tick is empty.
      wait_for_reports();
      csr_write(ftpr_pkg::REG_ENTRIES_IN_USE, 0);
      send_fault_item(ftpr_pkg::MODE_SET, 4'd0, 16'hFFFF, 2'd0);
      send_fault_item(ftpr_pkg::MODE_CLEAR, 4'd0, 16'h0000, 2'd0);
      send_fault_item(ftpr_pkg::MODE_SET_ALL, 4'd0, 16'h0000, 2'd0);
      send_fault_item(ftpr_pkg::MODE_TICK, 4'd0, 16'h0000, 2'd0);
      send_fault_item(ftpr_pkg::MODE_LOAD, 4'd3, 16'h0077, 2'd1);
      // A count above the table size saturates.
      wait_for_reports();
      csr_write(ftpr_pkg::REG_ENTRIES_IN_USE, 31);
      send_fault_item(ftpr_pkg::MODE_SET_ALL, 4'd0, 16'h0000, 2'd0);
      send_fault_item(ftpr_pkg::MODE_TICK, 4'd0, 16'h0000, 2'd0);
      // Reversed order reports the lowest active level, zero included.
      wait_for_reports();
      csr_write(ftpr_pkg::REG_ENTRIES_IN_USE, 16);
      csr_write(ftpr_pkg::REG_LEVEL_ORDER, 1);
      send_fault_item(ftpr_pkg::MODE_CLEAR_ALL, 4'd0, 16'h0000, 2'd0);
      send_fault_item(ftpr_pkg::MODE_SET, 4'd0, 16'hFFFF, 2'd0);
      send_fault_item(ftpr_pkg::MODE_SET, 4'd0, 16'h1234, 2'd0);
      send_fault_item(ftpr_pkg::MODE_TICK, 4'd0, 16'h0000, 2'd0);
      send_fault_item(ftpr_pkg::MODE_TICK, 4'd0, 16'h0000, 2'd0);
      send_fault_item(ftpr_pkg::MODE_TICK, 4'd0, 16'h0000, 2'd0);
      // Shrinking the span can leave the pointer beyond it.
      wait_for_reports();
      csr_write(ftpr_pkg::REG_ENTRIES_IN_USE, 4);
      send_fault_item(ftpr_pkg::MODE_SET_ALL, 4'd0, 16'h0000, 2'd0);
      send_fault_item(ftpr_pkg::MODE_TICK, 4'd0, 16'h0000, 2'd0);
      wait_for_reports();
      csr_write(ftpr_pkg::REG_ENTRIES_IN_USE, 1);
      csr_write(ftpr_pkg::REG_LEVEL_ORDER, 0);
      send_fault_item(ftpr_pkg::MODE_LOAD, 4'd0, 16'hC3C3, 2'd2);
      send_fault_item(ftpr_pkg::MODE_SET, 4'd0, 16'hC3C3, 2'd0);
      send_fault_item(ftpr_pkg::MODE_TICK, 4'd0, 16'h0000, 2'd0);
      send_fault_item(ftpr_pkg::MODE_TICK, 4'd0, 16'h0000, 2'd0);
   endtask

   task automatic test_random_traffic();
      run_random_phase(16, 1'b0, 70, 1'b1);
      run_random_phase(1, 1'b1, 40, 1'b1);
      run_random_phase(5, 1'b0, 60, 1'b0);
      run_random_phase(31, 1'b1, 60, 1'b1);
      run_random_phase(0, 1'b0, 25, 1'b1);
      run_random_phase(9, 1'b1, 60, 1'b1);
      run_random_phase(16, 1'b1, 60, 1'b1);
      run_random_phase(12, 1'b0, 60, 1'b0);
   endtask

   // The receiver stalls for a long stretch while requests keep coming, so
   // the response register fills and the request side has to back off.
   task automatic test_response_hold_off();
      run_random_phase(16, 1'b0, 0, 1'b0);
      hold_off_next = 1'b1;
      repeat (15) send_random_item();
      idling_on = 1'b1;
   endtask

   // Response side: draws a stall for every beat, or the long hold when asked.
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = idling_on ? $urandom_range(0, 7) : 0;
         if (hold_off_next) begin
            stall         = LONG_HOLD_CYCLES;
            hold_off_next = 1'b0;
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   always @(posedge clock) begin
      fault_report_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_reports.size() == 0) begin
            report_error("response beat with no request outstanding");
         end else begin
            want = expected_reports.pop_front();
            if (rsp_bus.status !== want.status)
               report_error($sformatf("status got %0d expected %0d",
                                      rsp_bus.status, want.status));
            if (rsp_bus.report_level !== want.level)
               report_error($sformatf("report_level got %0d expected %0d",
                                      rsp_bus.report_level, want.level));
            if (rsp_bus.report_code !== want.code)
               report_error($sformatf("report_code got %04h expected %04h",
                                      rsp_bus.report_code, want.code));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] watchdog: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("[fault_table_priority_reporter] ERROR");
         $finish;
      end
   end

   initial begin
      reset_table_model();
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.mode        <= '0;
      req_bus.entry_index <= '0;
      req_bus.fault_code  <= '0;
      req_bus.fault_level <= '0;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed_table_ops();
      test_span_and_order_edges();
      test_random_traffic();
      test_response_hold_off();

      wait_for_reports();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_reports.size() != 0)
         report_error($sformatf("%0d responses never arrived", expected_reports.size()));
      if (error_count == 0)
         $display("[fault_table_priority_reporter] OK");
      else
         $display("[fault_table_priority_reporter] ERROR");
      $finish;
   end

endmodule

@@ files.f @@
hdl/ftpr_pkg.sv
hdl/ftpr_req_if.sv
hdl/ftpr_rsp_if.sv
hdl/ftpr_csr.sv
hdl/ftpr_table.sv
hdl/ftpr_ctrl.sv
hdl/fault_table_priority_reporter.sv
hdl/ftpr_checker.sv
dv/tb_fault_table_priority_reporter.sv
